>>> sv/pal_pkg.sv
// Package: shared widths, operation and status codes, and control types for the list unit.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int CNT_PORT_W = 6;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] OP_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] OP_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] OP_READ   = 3'd2;
  localparam logic [MODE_W-1:0] OP_LOCATE = 3'd3;
  localparam logic [MODE_W-1:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic ins;   // shift up from the insert point, load the new value there
    logic del;   // shift down from the delete point
    logic load;  // capture match flag and read-back word
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

>>> sv/pal_if.sv
// Interfaces: operation request channel and result channel of the list unit.
`timescale 1ns / 1ps

interface pal_in_if import pal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pal_out_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  element;
  logic [CNT_PORT_W-1:0]    found_index;
  logic [CNT_PORT_W-1:0]    count;
  logic                     is_empty;

  modport source (output valid, status, element, found_index, count, is_empty, input ready);
  modport sink   (input valid, status, element, found_index, count, is_empty, output ready);
endinterface

>>> sv/positional_array_list_unit.sv
// Top level: ordered list of signed words held in a shifting chain of cells.
`timescale 1ns / 1ps

// The list lives in a row of DEPTH cells, one entry per cell; insert and
// delete move every entry past the given position one cell up or down all
// together, and locate compares the value against all cells at once. After
// the input transfer an operation passes through the execute state, which
// decodes it and applies it to the cells, and the done state, which reduces
// the per-cell match flags (first-match search) and read-back words into
// the result. The unit takes one operation at a time, so a new input is
// accepted only once the previous result has been registered; the result sits
// in an output register, so a stalled output only holds the unit once the
// next result is finished. Positions are 1-based; count and found_index are
// reported in six bits. Entries need no reset: only cells below the fill
// count are ever read or matched, and each of those has been written.
module positional_array_list_unit import pal_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_chan,
  pal_out_if.source out_chan
);

  localparam int CNT_W = ($clog2(DEPTH + 1) > 7) ? $clog2(DEPTH + 1) : 7;

  // Control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Captured operation
  logic [MODE_W-1:0]       mode_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] value_r;

  // Decode results carried from execute to completion
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              elem_ok_r, elem_ok_nxt;
  logic              is_loc_r, is_loc_nxt;

  // Output register
  logic [STAT_W-1:0]       o_status_r;
  logic signed [VAL_W-1:0] o_element_r;
  logic [CNT_PORT_W-1:0]   o_found_r;
  logic [CNT_PORT_W-1:0]   o_count_r;
  logic                    o_empty_r;

  logic                    in_xfer;
  logic                    out_free;
  cell_ctl_t               ctl;
  logic [CNT_W-1:0]        pos_ext;
  logic [CNT_W-1:0]        pos_idx;

  logic signed [VAL_W-1:0] cell_data  [DEPTH];
  logic signed [VAL_W-1:0] cell_rd    [DEPTH];
  logic                    cell_match [DEPTH];

  logic signed [VAL_W-1:0] rd_or;
  logic                    any_match;
  logic [CNT_W-1:0]        first_idx;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign pos_ext  = CNT_W'(pos_r);
  assign pos_idx  = pos_ext - 1'b1;

  // Decode the captured operation against the current fill count
  always_comb begin
    ctl         = '0;
    fill_nxt    = fill_r;
    status_nxt  = status_r;
    elem_ok_nxt = elem_ok_r;
    is_loc_nxt  = is_loc_r;
    if (state_r == S_EXEC) begin
      ctl.load    = 1'b1;
      status_nxt  = ST_OK;
      elem_ok_nxt = 1'b0;
      is_loc_nxt  = 1'b0;
      unique case (mode_r)
        OP_INSERT: begin
          if (fill_r >= CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else if (pos_r == '0 || pos_ext > fill_r + 1'b1) begin
            status_nxt = ST_BADPOS;
          end else begin
            ctl.ins  = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
        OP_DELETE, OP_READ: begin
          if (fill_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (pos_r == '0 || pos_ext > fill_r) begin
            status_nxt = ST_BADPOS;
          end else begin
            elem_ok_nxt = 1'b1;
            if (mode_r == OP_DELETE) begin
              ctl.del  = 1'b1;
              fill_nxt = fill_r - 1'b1;
            end
          end
        end
        OP_LOCATE: begin
          if (fill_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            is_loc_nxt = 1'b1;
          end
        end
        OP_CLEAR: begin
          fill_nxt = '0;
        end
        default: begin
          status_nxt = ST_BADPOS;
        end
      endcase
    end
  end

  // Cell chain: each cell sees both neighbors; the ends see zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    pal_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos_idx    (pos_idx),
      .fill       (fill_r),
      .value      (value_r),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .match_r    (cell_match[i]),
      .rd_r       (cell_rd[i])
    );
  end

  // Merge read-back words and find the lowest matching cell
  always_comb begin
    rd_or     = '0;
    any_match = 1'b0;
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      rd_or = rd_or | cell_rd[i];
      if (cell_match[i]) begin
        any_match = 1'b1;
        first_idx = CNT_W'(i + 1);
      end
    end
  end

  // Sequencer: accept, execute, complete
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= in_chan.mode;
      pos_r   <= in_chan.position;
      value_r <= in_chan.value;
    end
    status_r  <= status_nxt;
    elem_ok_r <= elem_ok_nxt;
    is_loc_r  <= is_loc_nxt;
    if (state_r == S_DONE && out_free) begin
      o_status_r  <= (is_loc_r && !any_match) ? ST_NOTFOUND : status_r;
      o_element_r <= elem_ok_r ? rd_or : '0;
      o_found_r   <= (is_loc_r && any_match) ? first_idx[CNT_PORT_W-1:0] : '0;
      o_count_r   <= fill_r[CNT_PORT_W-1:0];
      o_empty_r   <= (fill_r == '0);
    end
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = o_status_r;
  assign out_chan.element     = o_element_r;
  assign out_chan.found_index = o_found_r;
  assign out_chan.count       = o_count_r;
  assign out_chan.is_empty    = o_empty_r;

  // The list never holds more than DEPTH entries
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // The fill count only moves in the execute cycle
  a_fill_moves_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(fill_r)) |-> $past(state_r) == S_EXEC)
    else $error("fill count changed outside execute");

  // An accepted transfer always goes to execute next
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EXEC)
    else $error("accepted operation not executed");

  // A nonzero index is reported only with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_found_r != '0) |-> o_status_r == ST_OK)
    else $error("found index with failing status");

endmodule

>>> sv/pal_cell.sv
// One list cell: holds one entry, shifts with its neighbors, compares and reads back.
`timescale 1ns / 1ps

module pal_cell import pal_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]        pos_idx,
  input  logic [CNT_W-1:0]        fill,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  output logic signed [VAL_W-1:0] data,
  output logic                    match_r,
  output logic signed [VAL_W-1:0] rd_r
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic at_pos, above_pos;

  assign at_pos    = (MY_IDX == pos_idx);
  assign above_pos = (MY_IDX > pos_idx);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (at_pos) begin
        data_nxt = value;
      end else if (above_pos) begin
        data_nxt = left_data;
      end
    end else if (ctl.del) begin
      if (at_pos || above_pos) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.load) begin
      match_r <= (data_r == value) && (MY_IDX < fill);
      rd_r    <= at_pos ? data_r : '0;
    end
  end

  assign data = data_r;

endmodule

>>> tb/sv/tb.sv
// Testbench for positional_array_list_unit: random and directed list operations checked per field.
`timescale 1ns / 1ps

// Self-checking testbench for the positional list unit.
//
// An initial block builds the whole operation stream at time zero: a short
// directed opening that walks the empty, bad position and first match cases,
// then random phases that each lean toward growing, shrinking or churning the
// list, so it fills up to full and drains to empty many times. The generator
// tracks the fill count, so most positions are legal and most locate values
// are ones that were really inserted. The rest are bad positions, unknown
// modes and random values.
//
// A clocked driver feeds that stream into the request channel with random
// gaps. A clocked monitor runs the list predictor on every request transfer
// and checks each result transfer against the oldest prediction. The result
// channel stalls at random. The first operation of every phase is held until
// all predicted results have come back.
module tb;
  import pal_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int RANDOM_OPS = 1620;
  localparam int IDLE_LIMIT = 4000;   // cycles without any transfer
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_MAX = 10;

  localparam logic [MODE_W-1:0] OP_UNDEF_FIRST = OP_CLEAR + 1'b1;
  localparam logic [MODE_W-1:0] OP_UNDEF_LAST  = '1;
  localparam logic [POS_W-1:0]  POS_TOP        = '1;
  localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum int {PH_GROW, PH_SHRINK, PH_CHURN, PH_MIXED} phase_kind_t;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    int                      gap;    // idle cycles after this transfer
    bit                      drain;  // hold until every result is back
  } list_op_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] element;
    logic [CNT_PORT_W-1:0]   found_index;
    logic [CNT_PORT_W-1:0]   count;
    logic                    is_empty;
  } list_result_t;

  logic clk;
  logic rst_n;

  pal_in_if  in_chan();
  pal_out_if out_chan();

  positional_array_list_unit #(.DEPTH(LIST_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // Predictor state: its own copy of the list.
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int                      list_fill;

  list_op_t     op_queue[$];     // operations waiting to be driven
  list_result_t result_queue[$]; // predicted results, oldest first

  int n_taken;     // request transfers, updated nonblocking
  int n_returned;  // result transfers, updated nonblocking
  int mismatches;
  int idle_cycles;
  int gap_left;
  int mode_seen [8];
  int status_seen [8];
  int peak_fill;

  // Generator side: fill count as the stream will leave it, and inserted values.
  int                      gen_fill;
  logic signed [VAL_W-1:0] value_pool[$];

  // Apply one operation to the predicted list and return its result.
  function automatic list_result_t predict_list_op(list_op_t op);
    list_result_t r;
    int           p;
    r        = '0;
    r.status = ST_OK;
    p        = op.position;
    case (op.mode)
      OP_INSERT: begin
        if (list_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_fill + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (int k = list_fill; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = op.value;
          list_fill++;
        end
      end
      OP_DELETE, OP_READ: begin
        if (list_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_fill) begin
          r.status = ST_BADPOS;
        end else begin
          r.element = list_mem[p-1];
          if (op.mode == OP_DELETE) begin
            for (int k = p; k < list_fill; k++) list_mem[k-1] = list_mem[k];
            list_fill--;
          end
        end
      end
      OP_LOCATE: begin
        if (list_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (int k = 0; k < list_fill; k++) begin
            if (r.status == ST_NOTFOUND && list_mem[k] == op.value) begin
              r.status      = ST_OK;
              r.found_index = CNT_PORT_W'(k + 1);
            end
          end
        end
      end
      OP_CLEAR: list_fill = 0;
      default:  r.status = ST_BADPOS;
    endcase
    r.count    = CNT_PORT_W'(list_fill);
    r.is_empty = (list_fill == 0);
    return r;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(phase_kind_t ph);
    int r;
    int t_ins, t_del, t_rd, t_loc, t_clr;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW:   begin t_ins = 60; t_del = 70; t_rd = 80; t_loc = 96; t_clr = 97; end
      PH_SHRINK: begin t_ins = 15; t_del = 60; t_rd = 75; t_loc = 95; t_clr = 96; end
      PH_CHURN:  begin t_ins = 45; t_del = 80; t_rd = 88; t_loc = 97; t_clr = 98; end
      default:   begin t_ins = 30; t_del = 50; t_rd = 70; t_loc = 93; t_clr = 96; end
    endcase
    if (r < t_ins) return OP_INSERT;
    if (r < t_del) return OP_DELETE;
    if (r < t_rd)  return OP_READ;
    if (r < t_loc) return OP_LOCATE;
    if (r < t_clr) return OP_CLEAR;
    return MODE_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
  endfunction

  // Mostly legal positions, biased to both ends; the rest out of range.
  function automatic logic [POS_W-1:0] pick_position(logic [MODE_W-1:0] mode);
    int top;
    int r;
    if (mode != OP_INSERT && mode != OP_DELETE && mode != OP_READ)
      return POS_W'($urandom_range(0, POS_TOP));
    top = (mode == OP_INSERT) ? gen_fill + 1 : gen_fill;
    r   = $urandom_range(0, 99);
    if (top == 0 || r >= 88) begin
      if ($urandom_range(0, 2) == 0) return '0;
      return POS_W'($urandom_range(top + 1, POS_TOP));
    end
    if (r < 20) return 1;
    if (r < 40) return POS_W'(top);
    return POS_W'($urandom_range(1, top));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(logic [MODE_W-1:0] mode);
    int r;
    int pool_pct;
    r        = $urandom_range(0, 99);
    pool_pct = (mode == OP_LOCATE) ? 60 : 35;
    if (r < pool_pct && value_pool.size() != 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (r < pool_pct + 12) return pick_extreme();
    return $urandom;
  endfunction

  // Queue an operation and advance the generator's view of the fill count.
  task automatic add_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                        logic signed [VAL_W-1:0] value, int gap, bit drain);
    list_op_t op;
    op.mode     = mode;
    op.position = pos;
    op.value    = value;
    op.gap      = gap;
    op.drain    = drain;
    op_queue.push_back(op);
    case (mode)
      OP_INSERT: begin
        if (gen_fill < LIST_DEPTH && pos >= 1 && pos <= gen_fill + 1) begin
          gen_fill++;
          value_pool.push_back(value);
          if (value_pool.size() > 64) void'(value_pool.pop_front());
        end
      end
      OP_DELETE: if (gen_fill > 0 && pos >= 1 && pos <= gen_fill) gen_fill--;
      OP_CLEAR:  gen_fill = 0;
      default: ;
    endcase
  endtask

  // Driver: hold a pending transfer, then idle for the item's gap, then
  // present the next operation. A drain item waits for an empty pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else if (in_chan.valid && !in_chan.ready) begin
      // hold the current request
    end else if (gap_left > 0) begin
      in_chan.valid <= 1'b0;
      gap_left--;
    end else if (op_queue.size() == 0) begin
      in_chan.valid <= 1'b0;
    end else if (op_queue[0].drain && (in_chan.valid || n_taken != n_returned)) begin
      in_chan.valid <= 1'b0;
    end else begin
      list_op_t op;
      op = op_queue.pop_front();
      in_chan.valid    <= 1'b1;
      in_chan.mode     <= op.mode;
      in_chan.position <= op.position;
      in_chan.value    <= op.value;
      gap_left = op.gap;
    end
  end

  // Result side back-pressure: stretches of steady ready alternate with
  // stretches of random stalls.
  int  out_stretch;
  int  stall_left;
  bit  out_calm;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stretch = 0;
      stall_left  = 0;
    end else begin
      if (out_stretch == 0) begin
        out_calm    = ($urandom_range(0, 3) == 0);
        out_stretch = $urandom_range(50, 300);
      end else begin
        out_stretch--;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (!out_calm && $urandom_range(0, 99) < 30) begin
        out_chan.ready <= 1'b0;
        stall_left = pick_idle() - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction, then
  // predict for each request transfer. Results trail their requests through the
  // execute and done states, so checking first is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        list_result_t got;
        list_result_t want;
        got.status      = out_chan.status;
        got.element     = out_chan.element;
        got.found_index = out_chan.found_index;
        got.count       = out_chan.count;
        got.is_empty    = out_chan.is_empty;
        n_returned <= n_returned + 1;
        if (result_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] unexpected result: status %0d element %0d found %0d count %0d empty %0b",
                     $realtime, got.status, got.element, got.found_index, got.count,
                     got.is_empty);
        end else begin
          want = result_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("[%0t] result %0d differs", $realtime, n_returned);
              $display("  expected status %0d element %0d found %0d count %0d empty %0b",
                       want.status, want.element, want.found_index, want.count,
                       want.is_empty);
              $display("  actual   status %0d element %0d found %0d count %0d empty %0b",
                       got.status, got.element, got.found_index, got.count, got.is_empty);
            end
          end
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        list_op_t     op;
        list_result_t r;
        op.mode     = in_chan.mode;
        op.position = in_chan.position;
        op.value    = in_chan.value;
        op.gap      = 0;
        op.drain    = 1'b0;
        r = predict_list_op(op);
        result_queue.push_back(r);
        n_taken <= n_taken + 1;
        mode_seen[op.mode]++;
        status_seen[r.status]++;
        if (list_fill > peak_fill) peak_fill = list_fill;
      end

      // Watchdog: drop the run if nothing moves for too long.
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, IDLE_LIMIT, result_queue.size());
        $display("positional_array_list_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    phase_kind_t ph;
    bit          calm_in;
    int          made;
    int          phase_len;
    logic [MODE_W-1:0] m;

    clk              = 1'b0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.mode     = OP_CLEAR;
    in_chan.position = '0;
    in_chan.value    = '0;
    out_chan.ready   = 1'b0;
    list_fill        = 0;
    n_taken          = 0;
    n_returned       = 0;
    mismatches       = 0;
    idle_cycles      = 0;
    peak_fill        = 0;
    gen_fill         = 0;
    foreach (mode_seen[i]) mode_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (list_mem[i]) list_mem[i] = '0;

    // Directed opening: empty list, bounds, ordering, first match, clear.
    add_op(OP_DELETE, 1,       5,        0, 1'b0);  // empty
    add_op(OP_READ,   1,       5,        0, 1'b0);  // empty
    add_op(OP_LOCATE, 0,       5,        0, 1'b0);  // empty
    add_op(OP_INSERT, 0,       7,        0, 1'b0);  // position zero
    add_op(OP_INSERT, 2,       7,        0, 1'b0);  // past the end
    add_op(OP_INSERT, 1,       VAL_MAX,  0, 1'b0);
    add_op(OP_INSERT, 1,       VAL_MIN,  0, 1'b0);  // new head
    add_op(OP_INSERT, 3,       '0,       0, 1'b0);  // append
    add_op(OP_INSERT, 2,       '1,       2, 1'b0);  // middle
    add_op(OP_INSERT, POS_TOP, 5,        0, 1'b0);  // far out of range
    add_op(OP_READ,   1,       '0,       0, 1'b0);
    add_op(OP_READ,   4,       '0,       0, 1'b0);
    add_op(OP_READ,   0,       '0,       0, 1'b0);
    add_op(OP_READ,   5,       '0,       0, 1'b0);  // one past the end
    add_op(OP_LOCATE, POS_TOP, '0,       0, 1'b0);
    add_op(OP_LOCATE, 0,       VAL_MIN,  0, 1'b0);
    add_op(OP_LOCATE, 0,       12345,    0, 1'b0);  // no match
    add_op(OP_INSERT, 5,       '1,       0, 1'b0);  // duplicate at tail
    add_op(OP_LOCATE, 0,       '1,       0, 1'b0);  // first of two matches
    add_op(OP_DELETE, 2,       '0,       0, 1'b0);
    add_op(OP_DELETE, POS_TOP, '0,       0, 1'b0);
    add_op(OP_UNDEF_FIRST, 1,  '0,       0, 1'b0);
    add_op(OP_UNDEF_LAST,  1,  '0,       0, 1'b0);
    add_op(OP_CLEAR,  1,       '0,       0, 1'b0);
    add_op(OP_READ,   1,       '0,       0, 1'b0);  // empty again
    add_op(OP_INSERT, 1,       32'h5555_aaaa, 0, 1'b0);

    // Random phases; the first item of each waits for a drained pipeline.
    made = 0;
    while (made < RANDOM_OPS) begin
      ph        = phase_kind_t'($urandom_range(PH_GROW, PH_MIXED));
      calm_in   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(100, 200);
      for (int i = 0; i < phase_len && made < RANDOM_OPS; i++) begin
        m = pick_mode(ph);
        add_op(m, pick_position(m), pick_value(m),
               (calm_in || $urandom_range(0, 99) < 55) ? 0 : pick_idle(), i == 0);
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (op_queue.size() != 0 || in_chan.valid || result_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d operations: %0d insert, %0d delete, %0d read, %0d locate, %0d clear, %0d undefined",
             n_taken, mode_seen[OP_INSERT], mode_seen[OP_DELETE], mode_seen[OP_READ],
             mode_seen[OP_LOCATE], mode_seen[OP_CLEAR],
             n_taken - mode_seen[OP_INSERT] - mode_seen[OP_DELETE] - mode_seen[OP_READ]
             - mode_seen[OP_LOCATE] - mode_seen[OP_CLEAR]);
    $display("statuses ok %0d, full %0d, bad position %0d, empty %0d, not found %0d; peak fill %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
             status_seen[ST_EMPTY], status_seen[ST_NOTFOUND], peak_fill, mismatches);
    if (mismatches == 0) begin
      $display("positional_array_list_unit: match");
    end else begin
      $display("positional_array_list_unit: mismatch");
    end
    $finish;
  end

endmodule
